// ----- rtl/core/onewire_rom_search_top_macros.svh -----
// assertion macros shared by the onewire rom search rtl
`ifndef ONEWIRE_ROM_SEARCH_TOP_MACROS_SVH
`define ONEWIRE_ROM_SEARCH_TOP_MACROS_SVH

// same-cycle implication, checked on every clock outside reset
`define OWS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every clock outside reset
`define OWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/ows_pkg.sv -----
// types, codes and helpers for the onewire rom search engine
package ows_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CODE_BITS   = 64;
    localparam int MAX_RES     = 3;

    localparam logic [7:0] CRC_POLY       = 8'h8C;
    localparam logic [6:0] NO_MARK        = 7'd64;
    localparam logic [7:0] MAX_FAIL_RESET = 8'd3;
    localparam logic [7:0] FAIL_SAT       = 8'hFF;
    localparam logic [4:0] SLOTS_LIMIT    = 5'(TABLE_SLOTS);

    // input operations
    localparam logic [1:0] OP_START    = 2'd0;
    localparam logic [1:0] OP_PRESENCE = 2'd1;
    localparam logic [1:0] OP_PAIR     = 2'd2;

    // bit pair codes
    localparam logic [1:0] PAIR_COLLIDE = 2'd0;
    localparam logic [1:0] PAIR_ONE     = 2'd1;
    localparam logic [1:0] PAIR_ZERO    = 2'd2;
    localparam logic [1:0] PAIR_ERROR   = 2'd3;

    // result actions
    localparam logic [3:0] ACT_RESET       = 4'd0;
    localparam logic [3:0] ACT_SEARCH_CMD  = 4'd1;
    localparam logic [3:0] ACT_READ_PAIR   = 4'd2;
    localparam logic [3:0] ACT_WRITE_BIT   = 4'd3;
    localparam logic [3:0] ACT_STORED      = 4'd4;
    localparam logic [3:0] ACT_REJECTED    = 4'd5;
    localparam logic [3:0] ACT_DONE        = 4'd6;
    localparam logic [3:0] ACT_BUS_ERROR   = 4'd7;
    localparam logic [3:0] ACT_NO_PRESENCE = 4'd8;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_DETECT = 3'b010,
        PH_SEARCH = 3'b100
    } t_phase;

    typedef struct packed {
        t_phase         phase;
        logic [6:0]     bit_position;
        logic [6:0]     last_disc;
        logic [6:0]     new_disc;
        logic [4:0]     good_count;
        logic [7:0]     fail_count;
        logic [63:0]    working_code;
        logic [7:0]     crc_accum;
    } t_state;

    typedef struct packed {
        logic [3:0]     action;
        logic           bit_value;
        logic [63:0]    dev_code;
        logic [3:0]     slot;
        logic [4:0]     node_count;
        logic           last;
    } t_result;

    typedef struct packed {
        t_state                     nxt;
        logic [1:0]                 n_res;
        t_result [MAX_RES-1:0]      res;
        logic                       store;
    } t_step;

    // one step of the reflected crc-8
    function automatic logic [7:0] crc_bit(input logic [7:0] crc, input logic b);
        logic [7:0] sh;
        sh = {1'b0, crc[7:1]};
        return (crc[0] ^ b) ? (sh ^ CRC_POLY) : sh;
    endfunction

endpackage

// ----- rtl/core/ows_step.sv -----
// next-state and result decode for one input word of the search engine
module ows_step (
    input  ows_pkg::t_state i_st,
    input  logic [7:0]      i_max_fail,
    input  logic [1:0]      i_op,
    input  logic            i_present,
    input  logic [1:0]      i_pair,
    output ows_pkg::t_step  o_step
);

    logic [5:0] pos;
    logic       b;
    logic [6:0] disc;
    logic [7:0] crc_n;
    logic [4:0] good_n;
    logic [7:0] fail_n;
    logic       keep_going;

    assign pos = i_st.bit_position[5:0];

    // bit choice for a pair read, with collision resolution
    always_comb begin
        b    = 1'b0;
        disc = i_st.new_disc;
        case (i_pair)
            ows_pkg::PAIR_ONE:  b = 1'b1;
            ows_pkg::PAIR_ZERO: b = 1'b0;
            default: begin
                if ({1'b0, pos} < i_st.last_disc) begin
                    b    = 1'b0;
                    disc = {1'b0, pos};
                end else if ({1'b0, pos} == i_st.last_disc) begin
                    b = 1'b1;
                end else begin
                    b = i_st.working_code[pos];
                    if (!b) begin
                        disc = {1'b0, pos};
                    end
                end
            end
        endcase
    end

    assign crc_n = ows_pkg::crc_bit(i_st.crc_accum, b);

    // main decode
    always_comb begin
        o_step       = '0;
        o_step.nxt   = i_st;
        good_n       = i_st.good_count;
        fail_n       = i_st.fail_count;
        keep_going   = 1'b0;
        case (i_op)
            ows_pkg::OP_START: begin
                if (i_st.phase == ows_pkg::PH_IDLE) begin
                    o_step.nxt.bit_position = ows_pkg::NO_MARK;
                    o_step.nxt.last_disc    = ows_pkg::NO_MARK;
                    o_step.nxt.new_disc     = ows_pkg::NO_MARK;
                    o_step.nxt.good_count   = '0;
                    o_step.nxt.fail_count   = '0;
                    o_step.nxt.crc_accum    = '0;
                    o_step.nxt.phase        = ows_pkg::PH_DETECT;
                    o_step.n_res            = 2'd1;
                    o_step.res[0].action    = ows_pkg::ACT_RESET;
                    o_step.res[0].last      = 1'b1;
                end
            end
            ows_pkg::OP_PRESENCE: begin
                if (i_st.phase == ows_pkg::PH_DETECT) begin
                    if (!i_present) begin
                        o_step.nxt.phase     = ows_pkg::PH_IDLE;
                        o_step.n_res         = 2'd1;
                        o_step.res[0].action = ows_pkg::ACT_NO_PRESENCE;
                        o_step.res[0].last   = 1'b1;
                    end else begin
                        o_step.nxt.bit_position = 7'(ows_pkg::CODE_BITS - 1);
                        o_step.nxt.new_disc     = ows_pkg::NO_MARK;
                        o_step.nxt.crc_accum    = '0;
                        o_step.nxt.phase        = ows_pkg::PH_SEARCH;
                        o_step.n_res            = 2'd2;
                        o_step.res[0].action    = ows_pkg::ACT_SEARCH_CMD;
                        o_step.res[1].action    = ows_pkg::ACT_READ_PAIR;
                        o_step.res[1].last      = 1'b1;
                    end
                end
            end
            ows_pkg::OP_PAIR: begin
                if (i_st.phase == ows_pkg::PH_SEARCH) begin
                    if (i_pair == ows_pkg::PAIR_ERROR) begin
                        o_step.nxt.phase     = ows_pkg::PH_IDLE;
                        o_step.n_res         = 2'd1;
                        o_step.res[0].action = ows_pkg::ACT_BUS_ERROR;
                        o_step.res[0].last   = 1'b1;
                    end else begin
                        o_step.nxt.working_code[pos] = b;
                        o_step.nxt.crc_accum         = crc_n;
                        o_step.nxt.new_disc          = disc;
                        o_step.res[0].action         = ows_pkg::ACT_WRITE_BIT;
                        o_step.res[0].bit_value      = b;
                        if (pos != 6'd0) begin
                            // more bits to go
                            o_step.nxt.bit_position = {1'b0, pos - 6'd1};
                            o_step.n_res            = 2'd2;
                            o_step.res[1].action    = ows_pkg::ACT_READ_PAIR;
                            o_step.res[1].last      = 1'b1;
                        end else begin
                            // code complete: store or reject, then continue or finish
                            o_step.nxt.last_disc    = disc;
                            o_step.nxt.bit_position = ows_pkg::NO_MARK;
                            o_step.nxt.new_disc     = ows_pkg::NO_MARK;
                            o_step.res[1].dev_code  = o_step.nxt.working_code;
                            if (crc_n == 8'd0 && i_st.good_count < ows_pkg::SLOTS_LIMIT) begin
                                o_step.store         = 1'b1;
                                o_step.res[1].action = ows_pkg::ACT_STORED;
                                o_step.res[1].slot   = i_st.good_count[3:0];
                                good_n               = i_st.good_count + 5'd1;
                            end else begin
                                o_step.res[1].action = ows_pkg::ACT_REJECTED;
                                if (i_st.fail_count != ows_pkg::FAIL_SAT) begin
                                    fail_n = i_st.fail_count + 8'd1;
                                end
                            end
                            o_step.nxt.good_count = good_n;
                            o_step.nxt.fail_count = fail_n;
                            keep_going = (disc < ows_pkg::NO_MARK)
                                && (good_n < ows_pkg::SLOTS_LIMIT)
                                && (fail_n < i_max_fail);
                            o_step.n_res       = 2'd3;
                            o_step.res[2].last = 1'b1;
                            if (keep_going) begin
                                o_step.nxt.phase     = ows_pkg::PH_DETECT;
                                o_step.res[2].action = ows_pkg::ACT_RESET;
                            end else begin
                                o_step.nxt.phase         = ows_pkg::PH_IDLE;
                                o_step.res[2].action     = ows_pkg::ACT_DONE;
                                o_step.res[2].node_count = good_n;
                            end
                        end
                    end
                end
            end
            default: begin
                o_step.n_res = 2'd0;
            end
        endcase
    end

endmodule

// ----- rtl/core/onewire_rom_search_top.sv -----
// top level of the onewire search rom enumeration engine
//
//  channel   dir  handshake                        payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tuser operation, tdata present+pair
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tuser action, tdata result, tlast
//  cfg       in   i_cfg_wr_en                      i_cfg_wr_data max_failed_codes
//
// an input word is decoded in the cycle it is accepted; its zero to three result
// words sit in a three-entry result buffer and leave one per cycle while the output is ready.
// a new word is taken while the buffer is empty or its final word leaves; an
// ignored word gives no results and loads nothing into the buffer.
// the result buffer drain sets the rate; the state update itself is registered on acceptance.
// synchronous active-low reset clears state and the buffer count, and sets config to its default.
// output stalls hold the buffer and back-pressure the input.
`include "onewire_rom_search_top_macros.svh"

module onewire_rom_search_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side: tuser = operation[1:0]
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata: device_present[0], bit_pair[2:1], zero[7:3]
    input  logic [7:0]  i_s_axis_tdata,
    input  logic [1:0]  i_s_axis_tuser,
    // master side: tuser = action[3:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata: bit_value[0], dev_code[64:1], slot[68:65], node_count[73:69], zero[79:74]
    output logic [79:0] o_m_axis_tdata,
    output logic [3:0]  o_m_axis_tuser,
    output logic        o_m_axis_tlast,
    // configuration: max_failed_codes
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data
);

    ows_pkg::t_state              r_st;
    logic [7:0]                   r_max_fail;
    ows_pkg::t_result             r_buf [ows_pkg::MAX_RES];
    logic [1:0]                   r_count;
    logic [1:0]                   r_rd;
    logic [63:0]                  r_table [ows_pkg::TABLE_SLOTS];
    ows_pkg::t_step               step;
    ows_pkg::t_result             cur;
    logic                         in_acc;
    logic                         out_acc;

    // decode
    ows_step u_step (
        .i_st       (r_st),
        .i_max_fail (r_max_fail),
        .i_op       (i_s_axis_tuser),
        .i_present  (i_s_axis_tdata[0]),
        .i_pair     (i_s_axis_tdata[2:1]),
        .o_step     (step)
    );

    // handshakes
    assign cur             = r_buf[r_rd];
    assign o_m_axis_tvalid = (r_count != 2'd0);
    assign out_acc         = o_m_axis_tvalid && i_m_axis_tready;
    assign o_s_axis_tready = (r_count == 2'd0) || ((r_count == 2'd1) && i_m_axis_tready);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    // output word
    assign o_m_axis_tuser = cur.action;
    assign o_m_axis_tlast = cur.last;
    assign o_m_axis_tdata = {6'd0, cur.node_count, cur.slot, cur.dev_code, cur.bit_value};

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_fail <= ows_pkg::MAX_FAIL_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_fail <= i_cfg_wr_data;
        end
    end

    // engine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase        <= ows_pkg::PH_IDLE;
            r_st.bit_position <= ows_pkg::NO_MARK;
            r_st.last_disc    <= ows_pkg::NO_MARK;
            r_st.new_disc     <= ows_pkg::NO_MARK;
            r_st.good_count   <= '0;
            r_st.fail_count   <= '0;
            r_st.working_code <= '0;
            r_st.crc_accum    <= '0;
        end else if (in_acc) begin
            r_st <= step.nxt;
        end
    end

    // result buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rd    <= '0;
        end else if (in_acc && step.n_res != 2'd0) begin
            r_count <= step.n_res;
            r_rd    <= '0;
        end else if (out_acc) begin
            r_count <= r_count - 2'd1;
            r_rd    <= r_rd + 2'd1;
        end
    end

    // result buffer payload
    always_ff @(posedge i_clk) begin
        if (in_acc && step.n_res != 2'd0) begin
            for (int i = 0; i < ows_pkg::MAX_RES; i++) begin
                r_buf[i] <= step.res[i];
            end
        end
    end

    // table of good codes
    always_ff @(posedge i_clk) begin
        if (in_acc && step.store) begin
            r_table[r_st.good_count[ows_pkg::SLOT_W-1:0]] <= step.nxt.working_code;
        end
    end

    // checks
    `OWS_ASSERT_IMPLY(a_final_word_last, o_m_axis_tvalid && r_count == 2'd1, o_m_axis_tlast, "final buffered word lacks tlast")
    `OWS_ASSERT_NEXT(a_burst_continues, out_acc && !o_m_axis_tlast, o_m_axis_tvalid, "result burst broken off")
    `OWS_ASSERT_IMPLY(a_search_pos, r_st.phase == ows_pkg::PH_SEARCH, !r_st.bit_position[6], "bit position out of range while searching")
    `OWS_ASSERT_IMPLY(a_good_bound, 1'b1, r_st.good_count <= ows_pkg::SLOTS_LIMIT, "good count beyond table size")

endmodule
